// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset
`define BHA_ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("%m: check failed");

// Default form on clk_i / rst_ni
`define BHA_ASSERT(lbl, prop) `BHA_ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

// File: hw/rtl/bha_pkg.sv
package bha_pkg;

  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned MAX_SCORES = 8;
  localparam int unsigned BIN_W      = $clog2(NUM_BINS);
  localparam int unsigned SIDX_W     = 3;

  localparam int unsigned CNT_W = 32;
  localparam int unsigned WGT_W = 48;
  localparam int unsigned SUM_W = 64;

  // row layout: count | weight | gradients[scores] | hessians[scores]
  localparam int unsigned WGT_LO  = CNT_W;
  localparam int unsigned GRAD_LO = CNT_W + WGT_W;
  localparam int unsigned HESS_LO = GRAD_LO + MAX_SCORES * SUM_W;
  localparam int unsigned ROW_W   = HESS_LO + MAX_SCORES * SUM_W;

  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 208;

  // config register indexes
  localparam logic [1:0] CFG_BITS_PER_ITEM = 2'd0;
  localparam logic [1:0] CFG_SCORE_COUNT   = 2'd1;
  localparam logic [1:0] CFG_HESS_EN       = 2'd2;
  localparam logic [1:0] CFG_SINGLE_BIN    = 2'd3;

  typedef enum logic [1:0] {
    REQ_ACC   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef struct packed {
    logic [6:0] bits_per_item;
    logic [3:0] score_count;
    logic       hessian_enable;
    logic       single_bin_mode;
  } cfg_t;

  typedef struct packed {
    req_e               kind;
    logic [BIN_W-1:0]   bin;
    logic [SIDX_W-1:0]  sidx;
    logic [7:0]         occ;
    logic [31:0]        weight;
    logic [31:0]        grad;
    logic [31:0]        hess;
  } op_t;

endpackage

// File: hw/rtl/bha_ram.sv
module bha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bha_front.sv
module bha_front import bha_pkg::*; (
  input  cfg_t              cfg_i,
  input  logic [1:0]        req_type_i,
  input  logic [63:0]       packed_bins_i,
  input  logic [5:0]        slot_i,
  input  logic [SIDX_W-1:0] score_index_i,
  input  logic [7:0]        occurrences_i,
  input  logic [31:0]       sample_weight_i,
  input  logic [31:0]       gradient_i,
  input  logic [31:0]       hessian_i,
  input  logic [7:0]        read_bin_i,
  output logic              keep_o,
  output op_t               op_o
);

  logic [6:0]  bits;
  logic [12:0] shamt;
  logic [63:0] shifted;
  logic [63:0] mask;
  logic [63:0] bin_full;
  logic [3:0]  nsc;
  logic        acc_ok;
  req_e        kind;

  always_comb begin
    bits    = (cfg_i.bits_per_item > 7'd64) ? 7'd64 : cfg_i.bits_per_item;
    shamt   = 13'(slot_i) * 13'(bits);
    shifted = (shamt >= 13'd64) ? 64'd0 : (packed_bins_i >> shamt[5:0]);
    mask    = (bits >= 7'd64) ? '1 : ((64'd1 << bits[5:0]) - 64'd1);
    bin_full = cfg_i.single_bin_mode ? 64'd0 : (shifted & mask);
    if (cfg_i.score_count == 4'd0) begin
      nsc = 4'd1;
    end else if (cfg_i.score_count > 4'(MAX_SCORES)) begin
      nsc = 4'(MAX_SCORES);
    end else begin
      nsc = cfg_i.score_count;
    end
    acc_ok = (bin_full[63:BIN_W] == '0) && ({1'b0, score_index_i} < nsc);
    kind   = req_e'(req_type_i);

    op_o.kind   = kind;
    op_o.sidx   = score_index_i;
    op_o.occ    = occurrences_i;
    op_o.weight = sample_weight_i;
    op_o.grad   = gradient_i;
    op_o.hess   = hessian_i;
    case (kind)
      REQ_ACC: begin
        op_o.bin = bin_full[BIN_W-1:0];
        keep_o   = acc_ok;
      end
      REQ_READ, REQ_CLEAR: begin
        op_o.bin = read_bin_i;
        keep_o   = 1'b1;
      end
      default: begin
        op_o.bin = read_bin_i;
        keep_o   = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/bha_queue.sv
`include "assert_macros.svh"

module bha_queue import bha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output op_t  op_o
);

  op_t        slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= op_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = slot_q[rptr_q];

  `BHA_ASSERT(a_no_pop_empty, pop_i |-> cnt_q != 2'd0)
  `BHA_ASSERT(a_no_push_full, push_i |-> cnt_q != 2'd2)
  `BHA_ASSERT(a_cnt_in_range, cnt_q != 2'd3)

endmodule

// File: hw/rtl/bha_back.sv
`include "assert_macros.svh"

module bha_back import bha_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  q_valid_i,
  input  op_t                   q_op_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_MUL  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [NUM_BINS-1:0]   vld_q, vld_d;
  op_t                   op_q;
  logic                  hit_q;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [SUM_W-1:0]      pg_q, ph_q;

  logic                  ram_re, ram_we;
  logic [ROW_W-1:0]      rdata, row, new_row;

  logic [65:0]           mg, mh;
  logic [SUM_W-1:0]      g_old, h_old, g_new, h_new;
  logic [SUM_W-1:0]      sg, sh;
  logic [CNT_W:0]        csum;
  logic [WGT_W:0]        wsum;

  bha_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BINS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_q.bin),
    .wdata_i (new_row),
    .re_i    (ram_re),
    .raddr_i (q_op_i.bin),
    .rdata_o (rdata)
  );

  // round half up to Q16.16 then saturating add
  function automatic logic [SUM_W-1:0] scale(input logic [SUM_W-1:0] p);
    logic [SUM_W:0] r;
    r = {p[SUM_W-1], p} + (SUM_W+1)'(32768);
    return {{15{r[SUM_W]}}, r[SUM_W:16]};
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  assign row = hit_q ? rdata : '0;
  assign mg  = $signed({op_q.grad[31], op_q.grad}) * $signed({1'b0, op_q.weight});
  assign mh  = $signed({op_q.hess[31], op_q.hess}) * $signed({1'b0, op_q.weight});

  always_comb begin
    g_old = row[GRAD_LO + op_q.sidx * SUM_W +: SUM_W];
    h_old = row[HESS_LO + op_q.sidx * SUM_W +: SUM_W];
    sg    = scale(pg_q);
    sh    = scale(ph_q);
    g_new = sat_add(g_old, sg);
    h_new = cfg_i.hessian_enable ? sat_add(h_old, sh) : h_old;
    csum  = {1'b0, row[CNT_W-1:0]} + (CNT_W+1)'(op_q.occ);
    wsum  = {1'b0, row[WGT_LO +: WGT_W]} + (WGT_W+1)'(op_q.weight);
    new_row = row;
    new_row[GRAD_LO + op_q.sidx * SUM_W +: SUM_W] = g_new;
    new_row[HESS_LO + op_q.sidx * SUM_W +: SUM_W] = h_new;
    if (op_q.sidx == '0) begin
      new_row[CNT_W-1:0]      = csum[CNT_W] ? '1 : csum[CNT_W-1:0];
      new_row[WGT_LO +: WGT_W] = wsum[WGT_W] ? '1 : wsum[WGT_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    q_pop_o     = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          if (q_op_i.kind == REQ_CLEAR) begin
            vld_d[q_op_i.bin] = 1'b0;
          end else begin
            ram_re  = 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (op_q.kind == REQ_READ) begin
          out_valid_d = 1'b1;
          out_data_d  = {row[HESS_LO + op_q.sidx * SUM_W +: SUM_W],
                         row[GRAD_LO + op_q.sidx * SUM_W +: SUM_W],
                         row[WGT_LO +: WGT_W], row[CNT_W-1:0]};
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        ram_we          = 1'b1;
        vld_d[op_q.bin] = 1'b1;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (q_pop_o) begin
      op_q  <= q_op_i;
      hit_q <= vld_q[q_op_i.bin];
    end
    if (state_q == ST_RD) begin
      pg_q <= mg[SUM_W-1:0];
      ph_q <= mh[SUM_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BHA_ASSERT(a_we_in_mul, ram_we |-> state_q == ST_MUL)
  `BHA_ASSERT(a_rd_after_issue, state_q == ST_RD |-> $past(ram_re))
  `BHA_ASSERT(a_result_from_rd, $rose(out_valid_q) |-> $past(state_q == ST_RD))

endmodule

// File: hw/rtl/boosting_histogram_accumulate_unit.sv
// Channel   | Dir | Payload
// s_axis    | in  | tuser: req_type; tdata: request fields (192 bits)
// m_axis    | out | tdata: bin_count, bin_weight, gradient_sum, hessian_sum
// cfg       | in  | cfg_we_i / cfg_idx_i / cfg_wdata_i, no read-back
//
// One request at a time in the back end: clear only drops a valid bit, read does a row read,
// accumulate does row read, multiply, add and write back; all share one row memory.
// A 2-entry queue lets the front take requests while the back end works.
// Reset is async active low; per-bin valid bits make every bin read as zero
// after reset, so no clearing pass is needed. Clear just drops the valid bit.
// A read result waits in the output register; the back end stalls until taken.
module boosting_histogram_accumulate_unit import bha_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cfg port
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [6:0]            cfg_wdata_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // packed_bins[63:0] slot[69:64] score_index[72:70] occurrences[80:73]
  // sample_weight[112:81] gradient[144:113] hessian[176:145] read_bin[184:177]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]            s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // bin_count[31:0] bin_weight[79:32] gradient_sum[143:80] hessian_sum[207:144]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t cfg_q;
  logic keep, full, push, q_valid, q_pop;
  op_t  f_op, q_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits_per_item   <= 7'd8;
      cfg_q.score_count     <= 4'd1;
      cfg_q.hessian_enable  <= 1'b0;
      cfg_q.single_bin_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BITS_PER_ITEM: cfg_q.bits_per_item   <= cfg_wdata_i;
        CFG_SCORE_COUNT:   cfg_q.score_count     <= cfg_wdata_i[3:0];
        CFG_HESS_EN:       cfg_q.hessian_enable  <= cfg_wdata_i[0];
        CFG_SINGLE_BIN:    cfg_q.single_bin_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // front: decode bin, drop out-of-range accumulates and unused codes
  bha_front u_front (
    .cfg_i           (cfg_q),
    .req_type_i      (s_axis_tuser),
    .packed_bins_i   (s_axis_tdata[63:0]),
    .slot_i          (s_axis_tdata[69:64]),
    .score_index_i   (s_axis_tdata[72:70]),
    .occurrences_i   (s_axis_tdata[80:73]),
    .sample_weight_i (s_axis_tdata[112:81]),
    .gradient_i      (s_axis_tdata[144:113]),
    .hessian_i       (s_axis_tdata[176:145]),
    .read_bin_i      (s_axis_tdata[184:177]),
    .keep_o          (keep),
    .op_o            (f_op)
  );

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full && keep;

  bha_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (f_op),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .op_o    (q_op)
  );

  bha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: tb/sv/tb_boosting_histogram_accumulate_unit.sv
module tb_boosting_histogram_accumulate_unit import bha_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // histogram shadow: same contents the block should hold
  class hist_scoreboard;
    logic [31:0]        cnt [NUM_BINS];
    logic [47:0]        wgt [NUM_BINS];
    logic signed [63:0] grd [NUM_BINS*MAX_SCORES];
    logic signed [63:0] hss [NUM_BINS*MAX_SCORES];
    logic [6:0] bits_per_item;
    logic [3:0] score_count;
    logic       hess_en;
    logic       single_bin;
    logic [207:0] pending_reads[$];
    int errors;
    int reads_seen;

    function new();
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt[i] = '0;
        wgt[i] = '0;
      end
      for (int i = 0; i < NUM_BINS*MAX_SCORES; i++) begin
        grd[i] = '0;
        hss[i] = '0;
      end
      bits_per_item = 7'd8;
      score_count   = 4'd1;
      hess_en       = 1'b0;
      single_bin    = 1'b0;
      errors = 0;
      reads_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        CFG_BITS_PER_ITEM: bits_per_item = val;
        CFG_SCORE_COUNT:   score_count   = val[3:0];
        CFG_HESS_EN:       hess_en       = val[0];
        default:           single_bin    = val[0];
      endcase
    endfunction

    // signed Q16.16 * unsigned Q16.16, round half up, back to Q16.16
    function logic signed [63:0] scale_q16(logic signed [31:0] v, logic [31:0] w);
      logic signed [63:0] p;
      p = 64'(v) * $signed({32'd0, w}) + 64'sd32768;
      return p >>> 16;
    endfunction

    function logic signed [63:0] sat_add64(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
        s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s;
    endfunction

    function void note_request(req_e kind, logic [191:0] d);
      logic [63:0] packed_w, mask, bin;
      logic [5:0]  slot;
      logic [2:0]  sidx;
      logic [7:0]  occ, rbin;
      logic [31:0] w;
      logic signed [31:0] g, h;
      int bits, nsc, shamt, k;
      logic [32:0] c;
      logic [48:0] s;
      logic [207:0] r;
      packed_w = d[63:0];
      slot = d[69:64];
      sidx = d[72:70];
      occ  = d[80:73];
      w    = d[112:81];
      g    = d[144:113];
      h    = d[176:145];
      rbin = d[184:177];
      case (kind)
        REQ_ACC: begin
          bits = (bits_per_item > 64) ? 64 : bits_per_item;
          nsc = (score_count == 0) ? 1 : (score_count > MAX_SCORES ? MAX_SCORES : score_count);
          bin = '0;
          if (!single_bin) begin
            shamt = slot * bits;
            mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
            bin = ((shamt >= 64) ? 64'd0 : (packed_w >> shamt)) & mask;
          end
          if (bin < NUM_BINS && sidx < nsc) begin
            k = bin * MAX_SCORES + sidx;
            grd[k] = sat_add64(grd[k], scale_q16(g, w));
            if (hess_en) hss[k] = sat_add64(hss[k], scale_q16(h, w));
            if (sidx == 0) begin
              c = cnt[bin] + occ;
              s = wgt[bin] + w;
              cnt[bin] = c[32] ? '1 : c[31:0];
              wgt[bin] = s[48] ? '1 : s[47:0];
            end
          end
        end
        REQ_READ: begin
          k = rbin * MAX_SCORES + sidx;
          r = {hss[k], grd[k], wgt[rbin], cnt[rbin]};
          pending_reads.push_back(r);
        end
        REQ_CLEAR: begin
          cnt[rbin] = '0;
          wgt[rbin] = '0;
          for (int i = 0; i < MAX_SCORES; i++) begin
            grd[rbin*MAX_SCORES+i] = '0;
            hss[rbin*MAX_SCORES+i] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [207:0] got);
      logic [207:0] e;
      reads_seen++;
      if (pending_reads.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending_reads.pop_front();
      if (got[31:0] !== e[31:0]) begin
        $error("bin_count exp %0d got %0d", e[31:0], got[31:0]); errors++;
      end
      if (got[79:32] !== e[79:32]) begin
        $error("bin_weight exp %h got %h", e[79:32], got[79:32]); errors++;
      end
      if (got[143:80] !== e[143:80]) begin
        $error("gradient_sum exp %h got %h", e[143:80], got[143:80]); errors++;
      end
      if (got[207:144] !== e[207:144]) begin
        $error("hessian_sum exp %h got %h", e[207:144], got[207:144]); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [6:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  hist_scoreboard sb = new();
  int send_idle_pct = 31;   // sender idle share, per cent
  int recv_idle_pct = 74;   // receiver idle share, per cent
  bit hold_off = 1'b0;      // long receiver hold-off request
  int idle_cycles = 0;
  int requests_sent = 0;

  boosting_histogram_accumulate_unit u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: sample at the rising edge, decide tready at the falling one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no handshake on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one request; valid stays high across back-to-back requests
  task automatic send_request(req_e kind, logic [191:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(kind, d);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic finish_stream();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [191:0] make_fields(logic [63:0] pw, logic [5:0] slot,
      logic [2:0] sidx, logic [7:0] occ, logic [31:0] w, logic [31:0] g,
      logic [31:0] h, logic [7:0] rbin);
    return {7'd0, rbin, h, g, w, occ, sidx, slot, pw};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random request, biased toward accumulates hitting real bins
  task automatic send_random();
    logic [31:0] r;
    req_e kind;
    logic [191:0] d;
    r = $urandom_range(99);
    kind = req_e'((r < 70) ? REQ_ACC : (r < 90) ? REQ_READ : (r < 96) ? REQ_CLEAR : REQ_NONE);
    d = make_fields(($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(255)),
                    ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(1)),
                    3'($urandom_range(7)), 8'($urandom()),
                    ($urandom_range(7) == 0) ? $urandom() : 32'($urandom_range(1 << 18)),
                    $urandom(), $urandom(),
                    ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(15)));
    // narrow bins keep reads landing on populated entries
    if (kind != REQ_ACC && $urandom_range(1)) d[184:177] = 8'($urandom_range(3));
    send_request(kind, d);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // idle point: all reads returned, then let the accumulate pipe drain
  task automatic drain();
    finish_stream();
    while (sb.pending_reads.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(logic [6:0] bpi, logic [3:0] nsc, logic he, logic sbm);
    drain();
    write_reg(CFG_BITS_PER_ITEM, bpi);
    write_reg(CFG_SCORE_COUNT, {3'd0, nsc});
    write_reg(CFG_HESS_EN, {6'd0, he});
    write_reg(CFG_SINGLE_BIN, {6'd0, sbm});
  endtask

  initial begin
    logic [6:0] bpi_set[6];
    logic [3:0] nsc_set[6];
    bpi_set = '{7'd8, 7'd1, 7'd64, 7'd4, 7'd0, 7'd100};
    nsc_set = '{4'd8, 4'd1, 4'd8, 4'd3, 4'd0, 4'd15};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: a read of reset contents, then extremes and saturation
    set_config(7'd8, 4'd8, 1'b1, 1'b0);
    send_request(REQ_READ, make_fields(0, 0, 0, 0, 0, 0, 0, 8'd255));
    send_request(REQ_ACC, make_fields(64'h00ff, 0, 0, 8'd255, '1, 32'h7fffffff,
                                      32'h80000000, 0));
    repeat (3)
      send_request(REQ_ACC, make_fields(64'h00ff, 0, 0, 8'd255, '1, 32'h7fffffff,
                                        32'h80000000, 0));
    send_request(REQ_ACC, make_fields(64'hff00, 1, 3'd7, 8'd1, 32'h00010000,
                                      32'hffff8000, 32'h00008000, 0));
    send_request(REQ_READ, make_fields(0, 0, 0, 0, 0, 0, 0, 8'd255));
    send_request(REQ_READ, make_fields(0, 0, 3'd7, 0, 0, 0, 0, 8'd255));
    send_request(REQ_ACC, make_fields(rand64(), 6'd63, 0, 8'd3, 32'd5, 32'd7, 32'd9, 0));
    send_request(REQ_READ, make_fields(0, 0, 0, 0, 0, 0, 0, 8'd0));
    send_request(REQ_NONE, make_fields('1, '1, '1, '1, '1, '1, '1, '1));
    send_request(REQ_CLEAR, make_fields(0, 0, 0, 0, 0, 0, 0, 8'd255));
    send_request(REQ_READ, make_fields(0, 0, 3'd7, 0, 0, 0, 0, 8'd255));
    set_config(7'd8, 4'd1, 1'b0, 1'b1);
    send_request(REQ_ACC, make_fields('1, 6'd5, 0, 8'd2, 32'd65536, 32'd65536, 32'd3, 0));
    send_request(REQ_ACC, make_fields('1, 6'd5, 3'd1, 8'd2, 32'd65536, 32'd65536, 0, 0));
    send_request(REQ_READ, make_fields(0, 0, 0, 0, 0, 0, 0, 8'd0));

    // random phases across settings and idling modes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 74; recv_idle_pct = 31; end
      if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      set_config(bpi_set[ph], nsc_set[ph], 1'($urandom()), (ph == 5));
      if (ph == 4) begin
        // stall the result side while requests keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk_i);
            hold_off = 1'b0;
          end
          begin
            for (int i = 0; i < 40; i++)
              send_request(REQ_READ, make_fields(0, 0, 3'($urandom()), 0, 0, 0, 0,
                                                 8'($urandom_range(3))));
          end
        join
      end
      for (int i = 0; i < 160; i++) send_random();
    end

    drain();
    $display("requests sent: %0d, read results checked: %0d", requests_sent, sb.reads_seen);
    $display("covered six register settings, three idling modes and a long output stall");
    if (sb.errors == 0 && sb.pending_reads.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
